@@ hdl/best_quality_channel_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Channel allocator assertion macros
// Shared assertion wrappers used by the allocator top level.
// ----------------------------------------------------------------------------
`ifndef BEST_QUALITY_CHANNEL_ALLOCATOR_DEFINES_SVH
`define BEST_QUALITY_CHANNEL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BQCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqca: same-cycle check failed");

// next-cycle implication, disabled in reset
`define BQCA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqca: next-cycle check failed");

`endif

@@ hdl/bqca_pkg.sv @@
// ----------------------------------------------------------------------------
// Channel allocator package
// Sizes, codes and shared types of the best-quality channel allocator.
// ----------------------------------------------------------------------------
package bqca_pkg;

    localparam int TRAFFIC_ENTRIES    = 16;
    localparam int SIGNALLING_ENTRIES = 4;

    localparam int T_IDX_W = (TRAFFIC_ENTRIES > 1) ? $clog2(TRAFFIC_ENTRIES) : 1;
    localparam int S_IDX_W = (SIGNALLING_ENTRIES > 1) ? $clog2(SIGNALLING_ENTRIES) : 1;
    localparam int POS_W   = (T_IDX_W > S_IDX_W) ? T_IDX_W : S_IDX_W;
    localparam int CNT_W   = POS_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int ACTION_W  = 2;
    localparam int POOL_W    = 2;
    localparam int INDEX_W   = 4;
    localparam int QUALITY_W = 8;
    localparam int TRX_W     = 3;
    localparam int SLOT_W    = 3;
    localparam int STATUS_W  = 3;

    localparam logic [ACTION_W-1:0] ACT_ALLOC    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_NEXT = 2'd2;

    localparam logic [POOL_W-1:0] POOL_TRAFFIC = 2'd0;
    localparam logic [POOL_W-1:0] POOL_SIGNAL  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POOL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WRITTEN   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NEXT_SET  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NEXT_BUSY = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd7;

    typedef enum logic [2:0] {
        K_ALLOC_T,
        K_ALLOC_S,
        K_ALLOC_BAD,
        K_WRITE_T,
        K_WRITE_S,
        K_SET_NEXT,
        K_BAD
    } t_kind;

    typedef struct packed {
        logic                 eligible;
        logic                 free;
        logic [QUALITY_W-1:0] quality;
        logic [TRX_W-1:0]     trx;
        logic [SLOT_W-1:0]    slot;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        eligible: 1'b0, free: 1'b1, quality: '0, trx: '0, slot: '0};

    typedef struct packed {
        t_kind              kind;
        logic [INDEX_W-1:0] addr;
        t_entry             entry;
    } t_cmd;

endpackage

@@ hdl/bqca_queue.sv @@
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module bqca_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bqca_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output bqca_pkg::t_cmd  o_cmd
);

    localparam int AW = bqca_pkg::QUEUE_AW;
    localparam int DW = bqca_pkg::QUEUE_AW + 1;

    bqca_pkg::t_cmd r_mem [bqca_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wp, n_wp;
    logic [AW-1:0]  r_rp, n_rp;
    logic [DW-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == DW'(bqca_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == AW'(bqca_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(bqca_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ hdl/bqca_front.sv @@
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts input items and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module bqca_front (
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bqca_pkg::ACTION_W-1:0]      i_action,
    input  logic [bqca_pkg::POOL_W-1:0]        i_pool,
    input  logic [bqca_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic                               i_entry_eligible,
    input  logic                               i_entry_free,
    input  logic [bqca_pkg::QUALITY_W-1:0]     i_entry_quality,
    input  logic [bqca_pkg::TRX_W-1:0]         i_trx,
    input  logic [bqca_pkg::SLOT_W-1:0]        i_slot,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output bqca_pkg::t_cmd                     o_q_cmd
);

    logic t_idx_ok;
    logic s_idx_ok;

    assign t_idx_ok = (int'(i_entry_index) < bqca_pkg::TRAFFIC_ENTRIES);
    assign s_idx_ok = (int'(i_entry_index) < bqca_pkg::SIGNALLING_ENTRIES);

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_cmd.addr           = i_entry_index;
        o_q_cmd.entry.eligible = i_entry_eligible;
        o_q_cmd.entry.free     = i_entry_free;
        o_q_cmd.entry.quality  = i_entry_quality;
        o_q_cmd.entry.trx      = i_trx;
        o_q_cmd.entry.slot     = i_slot;
        o_q_cmd.kind           = bqca_pkg::K_BAD;
        unique case (i_action)
            bqca_pkg::ACT_ALLOC: begin
                if (i_pool == bqca_pkg::POOL_TRAFFIC) begin
                    o_q_cmd.kind = bqca_pkg::K_ALLOC_T;
                end else if (i_pool == bqca_pkg::POOL_SIGNAL) begin
                    o_q_cmd.kind = bqca_pkg::K_ALLOC_S;
                end else begin
                    o_q_cmd.kind = bqca_pkg::K_ALLOC_BAD;
                end
            end
            bqca_pkg::ACT_WRITE: begin
                if (i_pool == bqca_pkg::POOL_TRAFFIC && t_idx_ok) begin
                    o_q_cmd.kind = bqca_pkg::K_WRITE_T;
                end else if (i_pool == bqca_pkg::POOL_SIGNAL && s_idx_ok) begin
                    o_q_cmd.kind = bqca_pkg::K_WRITE_S;
                end
            end
            bqca_pkg::ACT_SET_NEXT: begin
                o_q_cmd.kind = bqca_pkg::K_SET_NEXT;
            end
            default: begin
                o_q_cmd.kind = bqca_pkg::K_BAD;
            end
        endcase
    end

endmodule

@@ hdl/bqca_back.sv @@
// ----------------------------------------------------------------------------
// Allocator back end
// Holds both pools, runs the entry-by-entry scans and drives the result.
// ----------------------------------------------------------------------------
module bqca_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_data,
    input  logic                               i_q_valid,
    input  bqca_pkg::t_cmd                     i_q_cmd,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_granted,
    output logic [bqca_pkg::INDEX_W-1:0]       o_granted_index,
    output logic [bqca_pkg::STATUS_W-1:0]      o_status
);

    localparam int TW = bqca_pkg::T_IDX_W;
    localparam int SW = bqca_pkg::S_IDX_W;
    localparam int PW = bqca_pkg::POS_W;
    localparam int CW = bqca_pkg::CNT_W;
    localparam int IW = bqca_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // pool storage, valid bit clear means reset contents
    bqca_pkg::t_entry r_t_mem [bqca_pkg::TRAFFIC_ENTRIES];
    bqca_pkg::t_entry r_s_mem [bqca_pkg::SIGNALLING_ENTRIES];
    logic [bqca_pkg::TRAFFIC_ENTRIES-1:0]    r_t_vld;
    logic [bqca_pkg::SIGNALLING_ENTRIES-1:0] r_s_vld;
    bqca_pkg::t_entry r_rd_t;
    bqca_pkg::t_entry r_rd_s;

    t_state                       r_state, n_state;
    bqca_pkg::t_cmd               r_cmd, n_cmd;
    logic                         r_blocked, n_blocked;
    logic [TW-1:0]                r_ptr_t, n_ptr_t;
    logic [SW-1:0]                r_ptr_s, n_ptr_s;
    logic [PW-1:0]                r_pos, n_pos;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_n, n_n;
    logic                         r_pend, n_pend;
    logic [PW-1:0]                r_rd_pos, n_rd_pos;
    logic                         r_found, n_found;
    logic                         r_best_ok, n_best_ok;
    logic [PW-1:0]                r_best_idx, n_best_idx;
    logic [bqca_pkg::QUALITY_W-1:0] r_best_q, n_best_q;
    bqca_pkg::t_entry             r_best_ent, n_best_ent;
    logic                         r_o_valid, n_o_valid;
    logic                         r_o_granted, n_o_granted;
    logic [IW-1:0]                r_o_gidx, n_o_gidx;
    logic [bqca_pkg::STATUS_W-1:0] r_o_status, n_o_status;

    logic             t_we;
    logic [TW-1:0]    t_waddr;
    bqca_pkg::t_entry t_wdata;
    logic             s_we;
    logic [SW-1:0]    s_waddr;
    bqca_pkg::t_entry s_wdata;
    logic [TW-1:0]    t_raddr;
    logic [SW-1:0]    s_raddr;
    logic             issue;
    logic             out_free;
    logic             is_alloc;
    bqca_pkg::t_entry rd_ent;
    bqca_pkg::t_entry wb_ent;

    assign t_raddr  = TW'(r_pos);
    assign s_raddr  = SW'(r_pos);
    assign issue    = (r_state == S_SCAN) && (r_cnt != r_n);
    assign out_free = !r_o_valid || !i_out_stall;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign rd_ent   = (r_cmd.kind == bqca_pkg::K_ALLOC_S) ? r_rd_s : r_rd_t;
    assign is_alloc = (i_q_cmd.kind == bqca_pkg::K_ALLOC_T) ||
                      (i_q_cmd.kind == bqca_pkg::K_ALLOC_S);

    always_comb begin
        wb_ent      = r_best_ent;
        wb_ent.free = 1'b0;
    end

    assign o_out_valid     = r_o_valid;
    assign o_granted       = r_o_granted;
    assign o_granted_index = r_o_gidx;
    assign o_status        = r_o_status;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_blocked  = i_cfg_valid ? i_cfg_data : r_blocked;
        n_ptr_t    = r_ptr_t;
        n_ptr_s    = r_ptr_s;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_pend     = issue;
        n_rd_pos   = r_pos;
        n_found    = r_found;
        n_best_ok  = r_best_ok;
        n_best_idx = r_best_idx;
        n_best_q   = r_best_q;
        n_best_ent = r_best_ent;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_granted = r_o_granted;
        n_o_gidx   = r_o_gidx;
        n_o_status = r_o_status;
        t_we       = 1'b0;
        t_waddr    = TW'(i_q_cmd.addr);
        t_wdata    = i_q_cmd.entry;
        s_we       = 1'b0;
        s_waddr    = SW'(i_q_cmd.addr);
        s_wdata    = i_q_cmd.entry;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cmd      = i_q_cmd;
                    n_cnt      = '0;
                    n_pend     = 1'b0;
                    n_found    = 1'b0;
                    n_best_ok  = 1'b0;
                    n_best_idx = '0;
                    n_best_q   = '0;
                    n_n        = CW'(bqca_pkg::TRAFFIC_ENTRIES);
                    n_pos      = '0;
                    if (i_q_cmd.kind == bqca_pkg::K_ALLOC_T) begin
                        n_pos = PW'(r_ptr_t);
                    end else if (i_q_cmd.kind == bqca_pkg::K_ALLOC_S) begin
                        n_pos = PW'(r_ptr_s);
                        n_n   = CW'(bqca_pkg::SIGNALLING_ENTRIES);
                    end
                    if ((is_alloc && !r_blocked) ||
                        i_q_cmd.kind == bqca_pkg::K_SET_NEXT) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                    t_we = (i_q_cmd.kind == bqca_pkg::K_WRITE_T);
                    s_we = (i_q_cmd.kind == bqca_pkg::K_WRITE_S);
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_cnt = r_cnt + 1'b1;
                    n_pos = ({1'b0, r_pos} == r_n - 1'b1) ? '0 : r_pos + 1'b1;
                end
                // one entry checked per cycle, read issued in the cycle before
                if (r_pend) begin
                    if (r_cmd.kind == bqca_pkg::K_SET_NEXT) begin
                        if (rd_ent.trx == r_cmd.entry.trx &&
                            rd_ent.slot == r_cmd.entry.slot) begin
                            n_found    = 1'b1;
                            n_best_idx = r_rd_pos;
                            n_best_ok  = rd_ent.eligible && rd_ent.free;
                        end
                    end else if (rd_ent.eligible && rd_ent.free &&
                                 rd_ent.quality > r_best_q) begin
                        n_found    = 1'b1;
                        n_best_idx = r_rd_pos;
                        n_best_q   = rd_ent.quality;
                        n_best_ent = rd_ent;
                    end
                end
                if (!r_pend && r_cnt == r_n) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_o_valid   = 1'b1;
                    n_o_granted = 1'b0;
                    n_o_gidx    = '0;
                    n_o_status  = bqca_pkg::ST_BAD_POOL;
                    case (r_cmd.kind)
                        bqca_pkg::K_ALLOC_T, bqca_pkg::K_ALLOC_S: begin
                            if (r_blocked) begin
                                n_o_status = bqca_pkg::ST_BLOCKED;
                            end else if (r_found) begin
                                n_o_granted = 1'b1;
                                n_o_gidx    = IW'(r_best_idx);
                                n_o_status  = bqca_pkg::ST_GRANTED;
                                if (r_cmd.kind == bqca_pkg::K_ALLOC_T) begin
                                    t_we    = 1'b1;
                                    t_waddr = TW'(r_best_idx);
                                    t_wdata = wb_ent;
                                    n_ptr_t = (r_best_idx ==
                                              PW'(bqca_pkg::TRAFFIC_ENTRIES - 1)) ?
                                              '0 : TW'(r_best_idx + 1'b1);
                                end else begin
                                    s_we    = 1'b1;
                                    s_waddr = SW'(r_best_idx);
                                    s_wdata = wb_ent;
                                    n_ptr_s = (r_best_idx ==
                                              PW'(bqca_pkg::SIGNALLING_ENTRIES - 1)) ?
                                              '0 : SW'(r_best_idx + 1'b1);
                                end
                            end else begin
                                n_o_status = bqca_pkg::ST_NONE_FREE;
                            end
                        end
                        bqca_pkg::K_ALLOC_BAD: begin
                            n_o_status = r_blocked ? bqca_pkg::ST_BLOCKED
                                                   : bqca_pkg::ST_BAD_POOL;
                        end
                        bqca_pkg::K_WRITE_T, bqca_pkg::K_WRITE_S: begin
                            n_o_status = bqca_pkg::ST_WRITTEN;
                        end
                        bqca_pkg::K_SET_NEXT: begin
                            if (r_found) begin
                                n_ptr_t    = TW'(r_best_idx);
                                n_o_status = r_best_ok ? bqca_pkg::ST_NEXT_SET
                                                       : bqca_pkg::ST_NEXT_BUSY;
                            end else begin
                                n_o_status = bqca_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_o_status = bqca_pkg::ST_BAD_POOL;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blocked   <= 1'b0;
            r_ptr_t     <= '0;
            r_ptr_s     <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_t_vld     <= '0;
            r_s_vld     <= '0;
            r_o_valid   <= 1'b0;
            r_o_granted <= 1'b0;
            r_o_gidx    <= '0;
            r_o_status  <= '0;
        end else begin
            r_state     <= n_state;
            r_blocked   <= n_blocked;
            r_ptr_t     <= n_ptr_t;
            r_ptr_s     <= n_ptr_s;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            if (t_we) begin
                r_t_vld[t_waddr] <= 1'b1;
            end
            if (s_we) begin
                r_s_vld[s_waddr] <= 1'b1;
            end
            r_o_valid   <= n_o_valid;
            r_o_granted <= n_o_granted;
            r_o_gidx    <= n_o_gidx;
            r_o_status  <= n_o_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_n        <= n_n;
        r_rd_pos   <= n_rd_pos;
        r_found    <= n_found;
        r_best_ok  <= n_best_ok;
        r_best_idx <= n_best_idx;
        r_best_q   <= n_best_q;
        r_best_ent <= n_best_ent;
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_t_mem[t_waddr] <= t_wdata;
        end
        r_rd_t <= r_t_vld[t_raddr] ? r_t_mem[t_raddr] : bqca_pkg::ENTRY_RESET;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_s_mem[s_waddr] <= s_wdata;
        end
        r_rd_s <= r_s_vld[s_raddr] ? r_s_mem[s_raddr] : bqca_pkg::ENTRY_RESET;
    end

endmodule

@@ hdl/best_quality_channel_allocator.sv @@
// ----------------------------------------------------------------------------
// Best-quality channel allocator
// Picks the free channel of highest quality from a traffic or signalling pool.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     i_in_valid / o_in_stall   i_action .. i_slot
//  result    o_out_valid / i_out_stall o_granted, o_granted_index, o_status
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (system blocked)
//
//  Allocate and set-next walk the pool one entry per cycle through that
//  pool's table read port; set-next always walks the traffic pool.
//  Write, refused and blocked items skip the scan in the back end.
//  A two-entry command queue keeps accepting items while the back end works.
//  Reset (synchronous, active low) empties both pools and zeroes the pointers.
//  A stalled result holds the back end; the queue then fills and stalls input.
`include "best_quality_channel_allocator_defines.svh"

module best_quality_channel_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bqca_pkg::ACTION_W-1:0]      i_action,
    input  logic [bqca_pkg::POOL_W-1:0]        i_pool,
    input  logic [bqca_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic                               i_entry_eligible,
    input  logic                               i_entry_free,
    input  logic [bqca_pkg::QUALITY_W-1:0]     i_entry_quality,
    input  logic [bqca_pkg::TRX_W-1:0]         i_trx,
    input  logic [bqca_pkg::SLOT_W-1:0]        i_slot,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_granted,
    output logic [bqca_pkg::INDEX_W-1:0]       o_granted_index,
    output logic [bqca_pkg::STATUS_W-1:0]      o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    bqca_pkg::t_cmd push_cmd;
    bqca_pkg::t_cmd pop_cmd;

    assign o_cfg_ready = 1'b1;

    bqca_front u_front (
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_pool           (i_pool),
        .i_entry_index    (i_entry_index),
        .i_entry_eligible (i_entry_eligible),
        .i_entry_free     (i_entry_free),
        .i_entry_quality  (i_entry_quality),
        .i_trx            (i_trx),
        .i_slot           (i_slot),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_cmd          (push_cmd)
    );

    bqca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd)
    );

    bqca_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_cmd         (pop_cmd),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_granted       (o_granted),
        .o_granted_index (o_granted_index),
        .o_status        (o_status)
    );

    `BQCA_ASSERT_IMP(a_pop_needs_data, i_clk, i_rst_n, q_pop, q_valid)
    `BQCA_ASSERT_NXT(a_one_cmd_at_a_time, i_clk, i_rst_n, q_pop, !q_pop)
    `BQCA_ASSERT_IMP(a_grant_status, i_clk, i_rst_n, o_out_valid && o_granted, o_status == bqca_pkg::ST_GRANTED)
    `BQCA_ASSERT_IMP(a_no_grant_index, i_clk, i_rst_n, o_out_valid && !o_granted, o_granted_index == '0)

endmodule

@@ tb/channel_grant_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel grant checker
// Watches the item, result and register channels of the allocator. It keeps
// its own copy of both pools and their rotating pointers, predicts one outcome
// per accepted item and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module channel_grant_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [bqca_pkg::ACTION_W-1:0]  i_action,
    input  logic [bqca_pkg::POOL_W-1:0]    i_pool,
    input  logic [bqca_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic                           i_entry_eligible,
    input  logic                           i_entry_free,
    input  logic [bqca_pkg::QUALITY_W-1:0] i_entry_quality,
    input  logic [bqca_pkg::TRX_W-1:0]     i_trx,
    input  logic [bqca_pkg::SLOT_W-1:0]    i_slot,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_granted,
    input  logic [bqca_pkg::INDEX_W-1:0]   i_granted_index,
    input  logic [bqca_pkg::STATUS_W-1:0]  i_status,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic                           i_cfg_data,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    import bqca_pkg::*;

    typedef struct packed {
        logic                granted;
        logic [INDEX_W-1:0]  index;
        logic [STATUS_W-1:0] status;
    } t_outcome;

    t_entry   traffic_tab [TRAFFIC_ENTRIES];
    t_entry   signal_tab  [SIGNALLING_ENTRIES];
    int       traffic_ptr;
    int       signal_ptr;
    logic     blocked;
    t_outcome outcomes_due [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic t_outcome predict_outcome(
        input logic [ACTION_W-1:0] action,
        input logic [POOL_W-1:0]   pool,
        input logic [INDEX_W-1:0]  index,
        input t_entry              fill
    );
        t_outcome res;
        t_entry   e;
        bit       signalling;
        int       size, pos, best, best_q, hit;
        res = '{granted: 1'b0, index: '0, status: ST_BAD_POOL};
        case (action)
            ACT_ALLOC: begin
                if (blocked) begin
                    res.status = ST_BLOCKED;
                end else if (pool == POOL_TRAFFIC || pool == POOL_SIGNAL) begin
                    signalling = (pool == POOL_SIGNAL);
                    size   = signalling ? SIGNALLING_ENTRIES : TRAFFIC_ENTRIES;
                    pos    = signalling ? signal_ptr : traffic_ptr;
                    best   = -1;
                    best_q = 0;
                    // one full lap from the pointer; strict compare keeps the first of a tie
                    for (int k = 0; k < size; k++) begin
                        e = signalling ? signal_tab[pos] : traffic_tab[pos];
                        if (e.eligible && e.free && int'(e.quality) > best_q) begin
                            best_q = int'(e.quality);
                            best   = pos;
                        end
                        pos = (pos + 1) % size;
                    end
                    if (best < 0) begin
                        res.status = ST_NONE_FREE;
                    end else begin
                        if (signalling) begin
                            signal_tab[best].free = 1'b0;
                            signal_ptr = (best + 1) % size;
                        end else begin
                            traffic_tab[best].free = 1'b0;
                            traffic_ptr = (best + 1) % size;
                        end
                        res.granted = 1'b1;
                        res.index   = best[INDEX_W-1:0];
                        res.status  = ST_GRANTED;
                    end
                end
            end
            ACT_WRITE: begin
                if (pool == POOL_TRAFFIC && index < TRAFFIC_ENTRIES) begin
                    traffic_tab[index] = fill;
                    res.status = ST_WRITTEN;
                end else if (pool == POOL_SIGNAL && index < SIGNALLING_ENTRIES) begin
                    signal_tab[index] = fill;
                    res.status = ST_WRITTEN;
                end
            end
            ACT_SET_NEXT: begin
                // traffic pool only, last match wins
                hit = -1;
                for (int i = 0; i < TRAFFIC_ENTRIES; i++) begin
                    if (traffic_tab[i].trx == fill.trx && traffic_tab[i].slot == fill.slot)
                        hit = i;
                end
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    traffic_ptr = hit;
                    res.status = (traffic_tab[hit].eligible && traffic_tab[hit].free) ?
                                 ST_NEXT_SET : ST_NEXT_BUSY;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome due;
        t_entry   fill;
        if (!i_rst_n) begin
            foreach (traffic_tab[i]) traffic_tab[i] = ENTRY_RESET;
            foreach (signal_tab[i]) signal_tab[i] = ENTRY_RESET;
            traffic_ptr = 0;
            signal_ptr  = 0;
            blocked     = 1'b0;
            outcomes_due.delete();
            o_outstanding = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                blocked = i_cfg_data;
            // retire before predicting so a new item never matches this transfer
            if (i_out_valid && !i_out_stall) begin
                if (outcomes_due.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding, status",
                                    int'(i_status), -1);
                end else begin
                    due = outcomes_due.pop_front();
                    if (i_granted !== due.granted)
                        report_mismatch("granted", int'(i_granted), int'(due.granted));
                    if (i_granted_index !== due.index)
                        report_mismatch("granted_index", int'(i_granted_index),
                                        int'(due.index));
                    if (i_status !== due.status)
                        report_mismatch("status", int'(i_status), int'(due.status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fill = '{eligible: i_entry_eligible, free: i_entry_free,
                         quality: i_entry_quality, trx: i_trx, slot: i_slot};
                outcomes_due.push_back(predict_outcome(i_action, i_pool, i_entry_index, fill));
            end
            o_outstanding = outcomes_due.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel allocator testbench
// Drives a directed set of writes, allocations and set-next items, then
// random phases under both blocking settings, with random gaps and stalls on
// both channels and one long result hold-off. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
    import bqca_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;

    localparam logic [ACTION_W-1:0]  ACT_UNUSED  = 2'd3;
    localparam logic [POOL_W-1:0]    POOL_BAD_LO = 2'd2;
    localparam logic [POOL_W-1:0]    POOL_BAD_HI = 2'd3;
    localparam int                   INDEX_MAX   = (1 << INDEX_W) - 1;
    localparam int                   QUALITY_MAX = (1 << QUALITY_W) - 1;
    localparam int                   TRX_MAX     = (1 << TRX_W) - 1;
    localparam int                   SLOT_MAX    = (1 << SLOT_W) - 1;
    localparam logic [INDEX_W-1:0]   INDEX_TOP   = '1;
    localparam logic [QUALITY_W-1:0] QUALITY_TOP = '1;
    localparam logic [TRX_W-1:0]     TRX_TOP     = '1;
    localparam logic [SLOT_W-1:0]    SLOT_TOP    = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACTION_W-1:0]  in_action;
    logic [POOL_W-1:0]    in_pool;
    logic [INDEX_W-1:0]   in_index;
    logic                 in_eligible;
    logic                 in_free;
    logic [QUALITY_W-1:0] in_quality;
    logic [TRX_W-1:0]     in_trx;
    logic [SLOT_W-1:0]    in_slot;
    logic                 out_valid;
    logic                 out_stall;
    logic                 out_granted;
    logic [INDEX_W-1:0]   out_index;
    logic [STATUS_W-1:0]  out_status;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    bit          no_gap    = 1'b0;
    bit          hold_go   = 1'b0;
    bit          hold_done = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    best_quality_channel_allocator dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_action         (in_action),
        .i_pool           (in_pool),
        .i_entry_index    (in_index),
        .i_entry_eligible (in_eligible),
        .i_entry_free     (in_free),
        .i_entry_quality  (in_quality),
        .i_trx            (in_trx),
        .i_slot           (in_slot),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_granted        (out_granted),
        .o_granted_index  (out_index),
        .o_status         (out_status),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    channel_grant_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_action         (in_action),
        .i_pool           (in_pool),
        .i_entry_index    (in_index),
        .i_entry_eligible (in_eligible),
        .i_entry_free     (in_free),
        .i_entry_quality  (in_quality),
        .i_trx            (in_trx),
        .i_slot           (in_slot),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_granted        (out_granted),
        .i_granted_index  (out_index),
        .i_status         (out_status),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // mostly short, now and then long
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, free stretches, one long hold-off on request
    initial begin
        int run;
        int pick;
        out_stall = 1'b0;
        run = 0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                out_stall = 1'b1;
                for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
                out_stall = 1'b0;
                hold_done = 1'b1;
            end else if (run > 0) begin
                run--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    out_stall = 1'b0;
                    run = $urandom_range(20, 80);
                end else if (pick < 50) begin
                    out_stall = 1'b1;
                    run = gap_length();
                end else begin
                    out_stall = 1'b0;
                    run = $urandom_range(0, 4);
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic offer(
        input logic [ACTION_W-1:0]  action,
        input logic [POOL_W-1:0]    pool,
        input logic [INDEX_W-1:0]   index,
        input logic                 eligible,
        input logic                 free_flag,
        input logic [QUALITY_W-1:0] quality,
        input logic [TRX_W-1:0]     trx,
        input logic [SLOT_W-1:0]    slot
    );
        int gap;
        gap = (no_gap || $urandom_range(0, 99) < 55) ? 0 : gap_length();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_action   = action;
        in_pool     = pool;
        in_index    = index;
        in_eligible = eligible;
        in_free     = free_flag;
        in_quality  = quality;
        in_trx      = trx;
        in_slot     = slot;
        in_valid    = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic offer_random();
        int                   pick;
        logic [ACTION_W-1:0]  action;
        logic [POOL_W-1:0]    pool;
        logic [INDEX_W-1:0]   index;
        logic [QUALITY_W-1:0] quality;
        logic [TRX_W-1:0]     trx;
        logic [SLOT_W-1:0]    slot;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            action = ACT_ALLOC;
        else if (pick < 80)
            action = ACT_WRITE;
        else if (pick < 95)
            action = ACT_SET_NEXT;
        else
            action = ACT_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            pool = POOL_TRAFFIC;
        else if (pick < 88)
            pool = POOL_SIGNAL;
        else if (pick < 94)
            pool = POOL_BAD_LO;
        else
            pool = POOL_BAD_HI;
        if (pool == POOL_SIGNAL && $urandom_range(0, 4) != 0)
            index = INDEX_W'($urandom_range(0, SIGNALLING_ENTRIES - 1));
        else
            index = INDEX_W'($urandom_range(0, INDEX_MAX));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            quality = '0;
        else if (pick < 20)
            quality = QUALITY_TOP;
        else
            quality = QUALITY_W'($urandom_range(1, QUALITY_MAX - 1));
        // a narrow trx/slot range so set-next finds matches often
        trx  = TRX_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                           : $urandom_range(0, TRX_MAX));
        slot = SLOT_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                            : $urandom_range(0, SLOT_MAX));
        offer(action, pool, index, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
              quality, trx, slot);
    endtask

    // register writes only once every result is back and the back end is quiet
    task automatic write_blocked(input logic value);
        in_valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_action   = ACT_ALLOC;
        in_pool     = POOL_TRAFFIC;
        in_index    = '0;
        in_eligible = 1'b0;
        in_free     = 1'b0;
        in_quality  = '0;
        in_trx      = '0;
        in_slot     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_blocked(1'b0);
        // empty pools, refused pools and the unused action
        offer(ACT_ALLOC,    POOL_TRAFFIC, 0, 0, 0, 0, 0, 0);
        offer(ACT_ALLOC,    POOL_SIGNAL,  0, 0, 0, 0, 0, 0);
        offer(ACT_ALLOC,    POOL_BAD_LO,  0, 0, 0, 0, 0, 0);
        offer(ACT_UNUSED,   POOL_BAD_HI,  INDEX_TOP, 1, 1, QUALITY_TOP, TRX_TOP, SLOT_TOP);
        // tie at top quality, quality zero, ineligible and assigned entries
        offer(ACT_WRITE,    POOL_TRAFFIC, INDEX_TOP, 1, 1, QUALITY_TOP, TRX_TOP, SLOT_TOP);
        offer(ACT_WRITE,    POOL_TRAFFIC, 0, 1, 1, 0, 1, 1);
        offer(ACT_WRITE,    POOL_TRAFFIC, 3, 1, 1, QUALITY_TOP, 2, 5);
        offer(ACT_WRITE,    POOL_TRAFFIC, 5, 0, 1, 200, 3, 3);
        offer(ACT_WRITE,    POOL_TRAFFIC, 6, 1, 0, 250, 3, 4);
        offer(ACT_WRITE,    POOL_SIGNAL,  INDEX_TOP, 1, 1, 9, 1, 1);
        offer(ACT_WRITE,    POOL_SIGNAL,  2, 1, 1, 1, 6, 6);
        offer(ACT_WRITE,    POOL_BAD_HI,  1, 1, 1, 10, 0, 0);
        offer(ACT_ALLOC,    POOL_TRAFFIC, 0, 0, 0, 0, 0, 0);
        offer(ACT_ALLOC,    POOL_TRAFFIC, 0, 0, 0, 0, 0, 0);
        offer(ACT_ALLOC,    POOL_TRAFFIC, 0, 0, 0, 0, 0, 0);
        offer(ACT_SET_NEXT, POOL_TRAFFIC, 0, 0, 0, 0, 2, 5);
        offer(ACT_SET_NEXT, POOL_TRAFFIC, 0, 0, 0, 0, 6, 1);
        offer(ACT_WRITE,    POOL_TRAFFIC, 9, 1, 1, 100, 4, 4);
        offer(ACT_SET_NEXT, POOL_BAD_HI,  0, 0, 0, 0, 4, 4);
        offer(ACT_ALLOC,    POOL_TRAFFIC, 0, 0, 0, 0, 0, 0);
        offer(ACT_ALLOC,    POOL_SIGNAL,  0, 0, 0, 0, 0, 0);
        offer(ACT_ALLOC,    POOL_SIGNAL,  0, 0, 0, 0, 0, 0);
        write_blocked(1'b1);
        offer(ACT_ALLOC,    POOL_TRAFFIC, 0, 0, 0, 0, 0, 0);
        offer(ACT_ALLOC,    POOL_BAD_HI,  0, 0, 0, 0, 0, 0);
        offer(ACT_WRITE,    POOL_TRAFFIC, 1, 1, 1, 50, 0, 1);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_blocked(phase % 3 == 2);
            no_gap = (phase == 3 || phase == 4);
            // long result hold-off while items keep coming back to back
            if (phase == 3)
                hold_go = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_random();
        end

        in_valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
